[sv/u8dcol_pkg.sv]
// shared constants and types for the utf-8 decoder with column tracking
package u8dcol_pkg;

   localparam int unsigned ByteBits     = 8;
   localparam int unsigned CodeBits     = 21;
   localparam int unsigned ColOutBits   = 16;
   localparam int unsigned PendBits     = 2;
   localparam int unsigned ColumnBitsDefault = 16;

   // lead byte boundaries
   localparam logic [ByteBits-1:0] LeadAsciiEnd = 8'h80;
   localparam logic [ByteBits-1:0] LeadTwoLo    = 8'hc0;
   localparam logic [ByteBits-1:0] LeadThreeLo  = 8'he0;
   localparam logic [ByteBits-1:0] LeadFourLo   = 8'hf0;
   localparam logic [ByteBits-1:0] LeadFourEnd  = 8'hf8;

   localparam logic [ByteBits-1:0] MaskTwo      = 8'b0001_1111;
   localparam logic [ByteBits-1:0] MaskThree    = 8'b0000_1111;
   localparam logic [ByteBits-1:0] MaskFour     = 8'b0000_0111;
   localparam logic [ByteBits-1:0] MaskCont     = 8'b0011_1111;
   localparam logic [CodeBits-1:0] NarrowMax    = 21'h00007f;

   // continuation bytes still expected after a lead byte
   localparam logic [PendBits-1:0] PendNone  = 2'd0;
   localparam logic [PendBits-1:0] PendOne   = 2'd1;
   localparam logic [PendBits-1:0] PendTwo   = 2'd2;
   localparam logic [PendBits-1:0] PendThree = 2'd3;

   // decoded result handed from the decode logic to the result register
   typedef struct packed {
      logic                  emit;
      logic [CodeBits-1:0]   code_point;
      logic [ColOutBits-1:0] column;
      logic                  double_width;
   } result_type;

endpackage

[sv/utf8_decode_with_column_advance_core.sv]
// top level: utf-8 byte stream decoder with character column tracking
//
// Takes one byte per item and decodes utf-8 without validation, giving one item per
// completed code point with the cell column where it starts and a double-width flag
// (set above 0x7f; the column then advances by two, otherwise by one, and saturates).
// A zero lead byte ends the string and clears the column; req_string_start clears the
// column and any partial sequence before its byte. Throughput is one byte per cycle while
// the output register is empty or being drained: a byte is held in the input register,
// is decoded there against the sequence state and its result lands in the output
// register, which drives rsp_valid. The input register loads whenever it is empty or its
// byte is being decoded, and decoding moves on whenever the output register is empty or
// being drained.
module utf8_decode_with_column_advance_core #(
   parameter int unsigned COLUMN_BITS = u8dcol_pkg::ColumnBitsDefault
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [u8dcol_pkg::ByteBits-1:0]   req_text_byte,
   input  logic                              req_string_start,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [u8dcol_pkg::CodeBits-1:0]   rsp_code_point,
   output logic [u8dcol_pkg::ColOutBits-1:0] rsp_column,
   output logic                              rsp_double_width
);
   import u8dcol_pkg::*;

   logic                   in_valid_ff;
   logic [ByteBits-1:0]    in_byte_ff;
   logic                   in_start_ff;
   logic [PendBits-1:0]    pending_ff, pending_in;
   logic [CodeBits-1:0]    partial_ff, partial_in;
   logic [COLUMN_BITS-1:0] column_ff, column_in;
   logic                   out_valid_ff;
   logic [CodeBits-1:0]    out_cp_ff;
   logic [ColOutBits-1:0]  out_col_ff;
   logic                   out_wide_ff;
   result_type             result;
   logic                   advance;
   logic                   process;

   u8dcol_decode #(
      .COLUMN_BITS (COLUMN_BITS)
   ) u_decode (
      .text_byte    (in_byte_ff),
      .string_start (in_start_ff),
      .pending      (pending_ff),
      .partial      (partial_ff),
      .column_count (column_ff),
      .pending_in   (pending_in),
      .partial_in   (partial_in),
      .column_in    (column_in),
      .result       (result)
   );

   assign advance   = !out_valid_ff || rsp_ready;
   assign process   = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pending_ff   <= PendNone;
         partial_ff   <= '0;
         column_ff    <= '0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= process && result.emit;
         end
         if (process) begin
            pending_ff <= pending_in;
            partial_ff <= partial_in;
            column_ff  <= column_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_byte_ff  <= req_text_byte;
         in_start_ff <= req_string_start;
      end
      if (process && result.emit) begin
         out_cp_ff   <= result.code_point;
         out_col_ff  <= result.column;
         out_wide_ff <= result.double_width;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_code_point   = out_cp_ff;
   assign rsp_column       = out_col_ff;
   assign rsp_double_width = out_wide_ff;

   // the width flag follows the code point
   a_wide_matches : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_double_width == (rsp_code_point > NarrowMax)))
      else $error("double width flag disagrees with code point");

   // the last continuation byte of a sequence always yields a result
   a_last_cont_emits : assert property (@(posedge clock) disable iff (reset)
      (process && !in_start_ff && pending_ff == PendOne) |=> rsp_valid)
      else $error("completed sequence gave no result");

   // reset empties both registers and drops any partial sequence
   a_reset_clears : assert property (@(posedge clock)
      reset |=> (!rsp_valid && !in_valid_ff && pending_ff == PendNone))
      else $error("reset left pipeline state");

endmodule

[sv/u8dcol_decode.sv]
// combinational decode of one byte against the running sequence and column state
module u8dcol_decode #(
   parameter int unsigned COLUMN_BITS = u8dcol_pkg::ColumnBitsDefault
) (
   input  logic [u8dcol_pkg::ByteBits-1:0] text_byte,
   input  logic                            string_start,
   input  logic [u8dcol_pkg::PendBits-1:0] pending,
   input  logic [u8dcol_pkg::CodeBits-1:0] partial,
   input  logic [COLUMN_BITS-1:0]          column_count,
   output logic [u8dcol_pkg::PendBits-1:0] pending_in,
   output logic [u8dcol_pkg::CodeBits-1:0] partial_in,
   output logic [COLUMN_BITS-1:0]          column_in,
   output u8dcol_pkg::result_type          result
);
   import u8dcol_pkg::*;

   logic [PendBits-1:0]    pend_eff;
   logic [CodeBits-1:0]    part_eff;
   logic [COLUMN_BITS-1:0] col_eff;
   logic [CodeBits-1:0]    shifted;
   logic                   emit;
   logic [CodeBits-1:0]    cp;
   logic                   wide;
   logic [COLUMN_BITS:0]   col_sum;
   logic [31:0]            col_ext;
   logic                   clear_col;

   always_comb begin
      // start of string drops any partial sequence and the column
      pend_eff = string_start ? PendNone : pending;
      part_eff = string_start ? '0 : partial;
      col_eff  = string_start ? '0 : column_count;

      shifted    = {part_eff[CodeBits-7:0], 6'b0} | CodeBits'(text_byte & MaskCont);
      emit       = 1'b0;
      cp         = CodeBits'(text_byte);
      pending_in = PendNone;
      partial_in = '0;
      clear_col  = 1'b0;

      if (pend_eff != PendNone) begin
         partial_in = shifted;
         pending_in = pend_eff - PendOne;
         cp         = shifted;
         emit       = (pend_eff == PendOne);
      end else if (text_byte == '0) begin
         // terminator ends the string
         clear_col = 1'b1;
      end else if (text_byte >= LeadTwoLo && text_byte < LeadThreeLo) begin
         partial_in = CodeBits'(text_byte & MaskTwo);
         pending_in = PendOne;
      end else if (text_byte >= LeadThreeLo && text_byte < LeadFourLo) begin
         partial_in = CodeBits'(text_byte & MaskThree);
         pending_in = PendTwo;
      end else if (text_byte >= LeadFourLo && text_byte < LeadFourEnd) begin
         partial_in = CodeBits'(text_byte & MaskFour);
         pending_in = PendThree;
      end else begin
         // ascii and stray bytes stand for themselves
         emit = 1'b1;
      end

      wide    = (cp > NarrowMax);
      col_sum = {1'b0, col_eff} + (wide ? (COLUMN_BITS+1)'(2) : (COLUMN_BITS+1)'(1));

      if (clear_col) begin
         column_in = '0;
      end else if (emit) begin
         column_in = col_sum[COLUMN_BITS] ? '1 : col_sum[COLUMN_BITS-1:0];
      end else begin
         column_in = col_eff;
      end

      col_ext             = 32'(col_eff);
      result.emit         = emit;
      result.code_point   = cp;
      result.column       = col_ext[ColOutBits-1:0];
      result.double_width = wide;
   end

endmodule
